FILE: rtl/hkv_pkg.sv
package hkv_pkg;

  localparam int WORD_W  = 32;
  localparam int COUNT_W = 11;
  localparam int OP_W    = 2;
  localparam int ST_W    = 2;

  localparam int DEF_BUCKETS = 256;
  localparam int DEF_WAYS    = 4;

  localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
  localparam logic [OP_W-1:0] OP_REPLACE = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd2;
  localparam logic [OP_W-1:0] OP_REMOVE  = 2'd3;

  localparam logic [ST_W-1:0] ST_DONE    = 2'd0;
  localparam logic [ST_W-1:0] ST_PRESENT = 2'd1;
  localparam logic [ST_W-1:0] ST_MISSING = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic              write;
    logic [ST_W-1:0]   status;
    logic [WORD_W-1:0] found;
    logic              inc;
    logic              dec;
  } hkv_result_t;

endpackage

FILE: rtl/hkv_bucket_mod.sv
module hkv_bucket_mod #(
  parameter int BUCKETS = hkv_pkg::DEF_BUCKETS,
  parameter int IDX_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [hkv_pkg::WORD_W-1:0] key,
  output logic                      done,
  output logic [IDX_W-1:0]          bucket
);

  localparam bit POW2 = (BUCKETS & (BUCKETS - 1)) == 0;

  generate
    if (POW2) begin : g_mask
      // A power-of-two bucket count is just the low key bits.
      assign done = start;
      if (BUCKETS == 1) begin : g_one
        assign bucket = '0;
      end else begin : g_bits
        assign bucket = key[IDX_W-1:0];
      end
    end else begin : g_recip
      // The quotient is the key times the rounded-up reciprocal of the bucket count,
      // which is exact for every 32-bit key. The remainder follows in a second stage.
      localparam int SHIFT   = hkv_pkg::WORD_W + $clog2(BUCKETS);
      localparam int RECIP_W = hkv_pkg::WORD_W + 1;
      localparam int PROD_W  = SHIFT + hkv_pkg::WORD_W;
      localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
      localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
      localparam logic [hkv_pkg::WORD_W-1:0] DIVISOR = BUCKETS;

      logic [PROD_W-1:0]          prod;
      logic [hkv_pkg::WORD_W-1:0] quot;
      logic [hkv_pkg::WORD_W-1:0] key_q;
      logic [hkv_pkg::WORD_W-1:0] rem_full;
      logic                       quot_valid;
      logic                       rem_valid;
      logic [IDX_W-1:0]           rem;

      assign prod     = PROD_W'(key) * PROD_W'(RECIP);
      assign rem_full = key_q - quot * DIVISOR;

      always_ff @(posedge clk) begin
        if (rst) begin
          quot_valid <= 1'b0;
          rem_valid  <= 1'b0;
        end else begin
          quot_valid <= start;
          rem_valid  <= quot_valid;
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          quot  <= prod[SHIFT +: hkv_pkg::WORD_W];
          key_q <= key;
        end
        if (quot_valid) begin
          rem <= rem_full[IDX_W-1:0];
        end
      end

      assign done   = rem_valid;
      assign bucket = rem;
    end
  endgenerate

endmodule

FILE: rtl/hkv_row_mem.sv
module hkv_row_mem #(
  parameter int DEPTH  = hkv_pkg::DEF_BUCKETS,
  parameter int WIDTH  = hkv_pkg::DEF_WAYS * (2 * hkv_pkg::WORD_W + 1),
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/hkv_way_logic.sv
module hkv_way_logic #(
  parameter int WAYS = hkv_pkg::DEF_WAYS
) (
  input  logic [hkv_pkg::OP_W-1:0]               op,
  input  logic [hkv_pkg::WORD_W-1:0]             key,
  input  logic [hkv_pkg::WORD_W-1:0]             value,
  input  logic [WAYS-1:0]                        row_valid,
  input  logic [WAYS-1:0][hkv_pkg::WORD_W-1:0]   row_keys,
  input  logic [WAYS-1:0][hkv_pkg::WORD_W-1:0]   row_vals,
  output logic [WAYS-1:0]                        new_valid,
  output logic [WAYS-1:0][hkv_pkg::WORD_W-1:0]   new_keys,
  output logic [WAYS-1:0][hkv_pkg::WORD_W-1:0]   new_vals,
  output hkv_pkg::hkv_result_t                   res
);

  logic [WAYS-1:0]            match;
  logic [WAYS-1:0]            hit_sel;
  logic [WAYS-1:0]            free_sel;
  logic                       hit;
  logic                       have_free;
  logic [hkv_pkg::WORD_W-1:0] hit_val;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      match[w] = row_valid[w] && (row_keys[w] == key);
    end
  end

  // Lowest matching way and lowest free way, as one-hot selects.
  always_comb begin
    hit       = 1'b0;
    have_free = 1'b0;
    hit_sel   = '0;
    free_sel  = '0;
    hit_val   = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (match[w] && !hit) begin
        hit_sel[w] = 1'b1;
        hit        = 1'b1;
      end
      if (!row_valid[w] && !have_free) begin
        free_sel[w] = 1'b1;
        have_free   = 1'b1;
      end
      hit_val = hit_val | (row_vals[w] & {hkv_pkg::WORD_W{hit_sel[w]}});
    end
  end

  always_comb begin
    new_valid = row_valid;
    new_keys  = row_keys;
    new_vals  = row_vals;
    res       = '0;
    res.status = hkv_pkg::ST_DONE;
    case (op)
      hkv_pkg::OP_INSERT: begin
        if (hit) begin
          res.status = hkv_pkg::ST_PRESENT;
        end else if (!have_free) begin
          res.status = hkv_pkg::ST_FULL;
        end else begin
          res.write = 1'b1;
          res.inc   = 1'b1;
          for (int w = 0; w < WAYS; w++) begin
            if (free_sel[w]) begin
              new_valid[w] = 1'b1;
              new_keys[w]  = key;
              new_vals[w]  = value;
            end
          end
        end
      end
      hkv_pkg::OP_REPLACE: begin
        if (hit) begin
          res.write = 1'b1;
          for (int w = 0; w < WAYS; w++) begin
            if (hit_sel[w]) begin
              new_vals[w] = value;
            end
          end
        end else begin
          res.status = hkv_pkg::ST_MISSING;
        end
      end
      hkv_pkg::OP_LOOKUP: begin
        if (hit) begin
          res.found = hit_val;
        end else begin
          res.status = hkv_pkg::ST_MISSING;
        end
      end
      hkv_pkg::OP_REMOVE: begin
        if (hit) begin
          res.write = 1'b1;
          res.dec   = 1'b1;
          new_valid = row_valid & ~hit_sel;
        end else begin
          res.status = hkv_pkg::ST_MISSING;
        end
      end
      default: begin
        res.status = hkv_pkg::ST_MISSING;
      end
    endcase
  end

endmodule

FILE: rtl/hashed_key_value_table.sv
// With a power-of-two bucket count the row is read as the item is accepted; otherwise
// the two-stage key remainder comes first. The result registers when the output is free.
// An item is accepted only while idle, so a new item waits for the bucket remainder and
// the read-modify-write of the last one's bucket row; a waiting result stalls the next.
// Reset: the live count clears at once, then a clearing pass writes every bucket row,
// during which no item is accepted.
module hashed_key_value_table #(
  parameter int BUCKETS = hkv_pkg::DEF_BUCKETS,
  parameter int WAYS    = hkv_pkg::DEF_WAYS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [hkv_pkg::OP_W-1:0]    req_type,
  input  logic [hkv_pkg::WORD_W-1:0]  key,
  input  logic [hkv_pkg::WORD_W-1:0]  value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [hkv_pkg::ST_W-1:0]    status,
  output logic [hkv_pkg::WORD_W-1:0]  found_value,
  output logic [hkv_pkg::COUNT_W-1:0] entry_count
);

  localparam int IDX_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int ROW_W  = WAYS * (2 * hkv_pkg::WORD_W + 1);
  localparam int KV_W   = WAYS * hkv_pkg::WORD_W;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_MOD   = 2'd2;
  localparam logic [1:0] S_LOOK  = 2'd3;

  logic [1:0]                  state;
  logic [IDX_W-1:0]            clr_addr;
  logic [IDX_W-1:0]            req_bucket;
  logic [hkv_pkg::OP_W-1:0]    req_op;
  logic [hkv_pkg::WORD_W-1:0]  req_key;
  logic [hkv_pkg::WORD_W-1:0]  req_value;
  logic [hkv_pkg::COUNT_W-1:0] live_count;
  logic [hkv_pkg::COUNT_W-1:0] live_count_next;

  logic                        accept;
  logic                        mod_done;
  logic [IDX_W-1:0]            mod_bucket;
  logic                        out_free;
  logic                        load_out;

  logic                        mem_we;
  logic [IDX_W-1:0]            mem_waddr;
  logic [ROW_W-1:0]            mem_wdata;
  logic [ROW_W-1:0]            rd_data;

  logic [WAYS-1:0]                      row_valid;
  logic [WAYS-1:0][hkv_pkg::WORD_W-1:0] row_keys;
  logic [WAYS-1:0][hkv_pkg::WORD_W-1:0] row_vals;
  logic [WAYS-1:0]                      new_valid;
  logic [WAYS-1:0][hkv_pkg::WORD_W-1:0] new_keys;
  logic [WAYS-1:0][hkv_pkg::WORD_W-1:0] new_vals;
  hkv_pkg::hkv_result_t                 res;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign load_out = (state == S_LOOK) && out_free;

  hkv_bucket_mod #(
    .BUCKETS (BUCKETS),
    .IDX_W   (IDX_W)
  ) u_mod (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .key    (key),
    .done   (mod_done),
    .bucket (mod_bucket)
  );

  // Row layout: valid bits on top, then the keys, then the values.
  assign row_valid = rd_data[ROW_W-1 -: WAYS];
  assign row_keys  = rd_data[2*KV_W-1 -: KV_W];
  assign row_vals  = rd_data[KV_W-1:0];

  // The write-back of one item lands before the next item's row read is issued.
  assign mem_we    = (state == S_CLEAR) || (load_out && res.write);
  assign mem_waddr = (state == S_CLEAR) ? clr_addr : req_bucket;
  assign mem_wdata = (state == S_CLEAR) ? '0 : {new_valid, new_keys, new_vals};

  hkv_row_mem #(
    .DEPTH  (BUCKETS),
    .WIDTH  (ROW_W),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mod_done),
    .raddr (mod_bucket),
    .rdata (rd_data)
  );

  hkv_way_logic #(
    .WAYS (WAYS)
  ) u_ways (
    .op        (req_op),
    .key       (req_key),
    .value     (req_value),
    .row_valid (row_valid),
    .row_keys  (row_keys),
    .row_vals  (row_vals),
    .new_valid (new_valid),
    .new_keys  (new_keys),
    .new_vals  (new_vals),
    .res       (res)
  );

  always_comb begin
    live_count_next = live_count;
    if (res.inc) begin
      live_count_next = live_count + 1'b1;
    end else if (res.dec) begin
      live_count_next = live_count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      live_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == IDX_W'(BUCKETS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state <= mod_done ? S_LOOK : S_MOD;
          end
        end
        S_MOD: begin
          if (mod_done) begin
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (out_free) begin
            state      <= S_IDLE;
            live_count <= live_count_next;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_op    <= req_type;
      req_key   <= key;
      req_value <= value;
    end
    if (mod_done) begin
      req_bucket <= mod_bucket;
    end
    if (load_out) begin
      status      <= res.status;
      found_value <= res.found;
      entry_count <= live_count_next;
    end
  end

  a_no_item_while_clearing: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !in_ready)
    else $error("item accepted during the clearing pass");

  a_found_only_on_done: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (found_value == '0 || status == hkv_pkg::ST_DONE))
    else $error("found value on a failed request");

  a_full_only_on_insert: assert property (@(posedge clk) disable iff (rst)
    (load_out && (res.status == hkv_pkg::ST_FULL || res.status == hkv_pkg::ST_PRESENT))
      |-> (req_op == hkv_pkg::OP_INSERT && !res.write))
    else $error("full or present status outside a failed insert");

  a_row_read_before_look: assert property (@(posedge clk) disable iff (rst)
    ((state == S_IDLE || state == S_MOD) && mod_done) |=> (state == S_LOOK))
    else $error("row read issued without moving to the lookup step");

endmodule

FILE: verif/hkv_table_checker.sv
module hkv_table_checker #(
  parameter int BUCKETS = hkv_pkg::DEF_BUCKETS,
  parameter int WAYS    = hkv_pkg::DEF_WAYS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [hkv_pkg::OP_W-1:0]    req_type,
  input  logic [hkv_pkg::WORD_W-1:0]  key,
  input  logic [hkv_pkg::WORD_W-1:0]  value,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [hkv_pkg::ST_W-1:0]    status,
  input  logic [hkv_pkg::WORD_W-1:0]  found_value,
  input  logic [hkv_pkg::COUNT_W-1:0] entry_count,
  output int                          mismatches,
  output int                          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = BUCKETS * WAYS;

  typedef struct packed {
    logic [hkv_pkg::ST_W-1:0]    status;
    logic [hkv_pkg::WORD_W-1:0]  found;
    logic [hkv_pkg::COUNT_W-1:0] count;
  } table_reply_t;

  logic [hkv_pkg::WORD_W-1:0]  slot_keys [SLOTS];
  logic [hkv_pkg::WORD_W-1:0]  slot_vals [SLOTS];
  bit                          slot_live [SLOTS];
  logic [hkv_pkg::COUNT_W-1:0] live_entries;
  table_reply_t                due_replies [$];
  table_reply_t                want;
  int                          err_total;

  // Applies one request to the shadow table and returns the reply it should produce.
  function automatic table_reply_t apply_request(logic [hkv_pkg::OP_W-1:0] op,
                                                 logic [hkv_pkg::WORD_W-1:0] k,
                                                 logic [hkv_pkg::WORD_W-1:0] v);
    table_reply_t r;
    int base;
    int hit_slot;
    int free_slot;
    bit hit;
    bit have_free;
    base = int'(k % 32'(BUCKETS)) * WAYS;
    hit = 1'b0;
    have_free = 1'b0;
    hit_slot = 0;
    free_slot = 0;
    r.status = hkv_pkg::ST_DONE;
    r.found = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (slot_live[base + w]) begin
        if (!hit && slot_keys[base + w] == k) begin
          hit = 1'b1;
          hit_slot = base + w;
        end
      end else if (!have_free) begin
        have_free = 1'b1;
        free_slot = base + w;
      end
    end
    case (op)
      hkv_pkg::OP_INSERT: begin
        // A present key wins over a full bucket.
        if (hit) begin
          r.status = hkv_pkg::ST_PRESENT;
        end else if (!have_free) begin
          r.status = hkv_pkg::ST_FULL;
        end else begin
          slot_keys[free_slot] = k;
          slot_vals[free_slot] = v;
          slot_live[free_slot] = 1'b1;
          live_entries = live_entries + 1'b1;
        end
      end
      hkv_pkg::OP_REPLACE: begin
        if (hit) slot_vals[hit_slot] = v;
        else r.status = hkv_pkg::ST_MISSING;
      end
      hkv_pkg::OP_LOOKUP: begin
        if (hit) r.found = slot_vals[hit_slot];
        else r.status = hkv_pkg::ST_MISSING;
      end
      default: begin
        if (hit) begin
          slot_live[hit_slot] = 1'b0;
          live_entries = live_entries - 1'b1;
        end else begin
          r.status = hkv_pkg::ST_MISSING;
        end
      end
    endcase
    r.count = live_entries;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < SLOTS; s++) slot_live[s] = 1'b0;
      live_entries = '0;
      due_replies.delete();
      err_total = 0;
    end else begin
      if (in_valid === 1'b1 && in_ready === 1'b1) begin
        due_replies.push_back(apply_request(req_type, key, value));
      end
      if (out_valid === 1'b1 && out_ready === 1'b1) begin
        if (due_replies.size() == 0) begin
          $error("result item with no request outstanding");
          err_total++;
        end else begin
          want = due_replies.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            err_total++;
          end
          if (found_value !== want.found) begin
            $error("found_value: expected %h, got %h", want.found, found_value);
            err_total++;
          end
          if (entry_count !== want.count) begin
            $error("entry_count: expected %0d, got %0d", want.count, entry_count);
            err_total++;
          end
        end
      end
    end
    mismatches <= err_total;
    outstanding <= due_replies.size();
  end

endmodule

FILE: verif/tb_hashed_key_value_table.sv
module tb_hashed_key_value_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASE_ITEMS = 150;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 24;

  logic                         clk;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [hkv_pkg::OP_W-1:0]     req_type = hkv_pkg::OP_LOOKUP;
  logic [hkv_pkg::WORD_W-1:0]   key = '0;
  logic [hkv_pkg::WORD_W-1:0]   value = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [hkv_pkg::ST_W-1:0]     status;
  logic [hkv_pkg::WORD_W-1:0]   found_value;
  logic [hkv_pkg::COUNT_W-1:0]  entry_count;

  int mismatches;
  int outstanding;
  int send_idle = 35;
  int recv_idle = 50;
  int cycle_cnt = 0;

  // Random keys crowd into a few buckets and reuse a few upper parts so that
  // buckets fill up and requests hit.
  logic [7:0]  hot_buckets [6];
  logic [23:0] hot_uppers [8];

  hashed_key_value_table u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .req_type(req_type),
    .key(key),
    .value(value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .found_value(found_value),
    .entry_count(entry_count)
  );

  hkv_table_checker u_checker (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .req_type(req_type),
    .key(key),
    .value(value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .found_value(found_value),
    .entry_count(entry_count),
    .mismatches(mismatches),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  task automatic send_item(input logic [hkv_pkg::OP_W-1:0] op,
                           input logic [hkv_pkg::WORD_W-1:0] k,
                           input logic [hkv_pkg::WORD_W-1:0] v);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= op;
    key <= k;
    value <= v;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  function automatic logic [hkv_pkg::WORD_W-1:0] pick_key();
    logic [7:0]  bkt;
    logic [23:0] upper;
    if ($urandom_range(99) < 10) return $urandom();
    bkt = ($urandom_range(99) < 75) ? hot_buckets[$urandom_range(5)] : 8'($urandom());
    upper = ($urandom_range(99) < 85) ? hot_uppers[$urandom_range(7)] : 24'($urandom());
    return {upper, bkt};
  endfunction

  function automatic logic [hkv_pkg::OP_W-1:0] pick_op();
    int r;
    r = $urandom_range(99);
    if (r < 35) return hkv_pkg::OP_INSERT;
    if (r < 50) return hkv_pkg::OP_REPLACE;
    if (r < 80) return hkv_pkg::OP_LOOKUP;
    return hkv_pkg::OP_REMOVE;
  endfunction

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    for (int i = 0; i < 6; i++) hot_buckets[i] = 8'($urandom());
    for (int i = 0; i < 8; i++) hot_uppers[i] = 24'($urandom());
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Empty table: every keyed operation misses.
    send_item(hkv_pkg::OP_LOOKUP,  32'h0000_0000, 32'hFFFF_FFFF);
    send_item(hkv_pkg::OP_REMOVE,  32'hFFFF_FFFF, 32'h0000_0000);
    send_item(hkv_pkg::OP_REPLACE, 32'h0000_0005, 32'h1234_5678);
    // Fill bucket 5, then try a fifth key and a duplicate on the full bucket.
    send_item(hkv_pkg::OP_INSERT,  32'h0000_0005, 32'hFFFF_FFFF);
    send_item(hkv_pkg::OP_INSERT,  32'h0000_0005, 32'h0BAD_0BAD);
    send_item(hkv_pkg::OP_INSERT,  32'h0000_0105, 32'h0000_0001);
    send_item(hkv_pkg::OP_INSERT,  32'hFFFF_FF05, 32'h8000_0000);
    send_item(hkv_pkg::OP_INSERT,  32'h8000_0005, 32'h7FFF_FFFF);
    send_item(hkv_pkg::OP_INSERT,  32'h0000_0205, 32'hDEAD_BEEF);
    send_item(hkv_pkg::OP_INSERT,  32'h0000_0105, 32'hCAFE_CAFE);
    send_item(hkv_pkg::OP_LOOKUP,  32'hFFFF_FF05, 32'h0000_0000);
    send_item(hkv_pkg::OP_REPLACE, 32'h0000_0105, 32'h0000_0000);
    send_item(hkv_pkg::OP_LOOKUP,  32'h0000_0105, 32'hFFFF_FFFF);
    // Removing one way leaves the rest of the bucket live; the freed way is reused.
    send_item(hkv_pkg::OP_REMOVE,  32'h0000_0005, 32'h0000_0000);
    send_item(hkv_pkg::OP_LOOKUP,  32'h8000_0005, 32'h0000_0000);
    send_item(hkv_pkg::OP_INSERT,  32'h0000_0205, 32'hDEAD_BEEF);
    send_item(hkv_pkg::OP_REMOVE,  32'h0000_0105, 32'h0000_0000);
    send_item(hkv_pkg::OP_LOOKUP,  32'h0000_0205, 32'h0000_0000);
    send_item(hkv_pkg::OP_LOOKUP,  32'h0000_0105, 32'h0000_0000);
    send_item(hkv_pkg::OP_INSERT,  32'hFFFF_FFFF, 32'hAAAA_AAAA);
    send_item(hkv_pkg::OP_LOOKUP,  32'hFFFF_FFFF, 32'h0000_0000);
    send_item(hkv_pkg::OP_INSERT,  32'h0000_0000, 32'h5555_5555);
    send_item(hkv_pkg::OP_LOOKUP,  32'h0000_0000, 32'h0000_0000);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle = 35;
          recv_idle = 50;
        end
        1: begin
          send_idle = 50;
          recv_idle = 35;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      repeat (PHASE_ITEMS) send_item(pick_op(), pick_key(), $urandom());
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: hashed_key_value_table.f
rtl/hkv_pkg.sv
rtl/hkv_bucket_mod.sv
rtl/hkv_row_mem.sv
rtl/hkv_way_logic.sv
rtl/hashed_key_value_table.sv
verif/hkv_table_checker.sv
verif/tb_hashed_key_value_table.sv
